[rtl/core/port_priority_classifier_defines.svh]
// assertion macros for the port priority classifier
// used by the top level only; needs nothing else
`ifndef PORT_PRIORITY_CLASSIFIER_DEFINES_SVH
`define PORT_PRIORITY_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
`define PPC_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PPC_ASSERT(label, prop, msg) \
  `PPC_ASSERT_RST(label, clk_i, rst_ni, prop, msg)
`else
`define PPC_ASSERT_RST(label, clk, rst_n, prop, msg)
`define PPC_ASSERT(label, prop, msg)
`endif
`endif

[rtl/core/ppc_pkg.sv]
// shared types and codes for the port priority classifier
// no dependencies
package ppc_pkg;

  localparam int TableCount     = 4;
  localparam int DefaultEntries = 16;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PROTO_UDP  = 2'd0,
    PROTO_TCP  = 2'd1,
    PROTO_ICMP = 2'd2
  } proto_e;

  typedef enum logic [1:0] {
    DIR_IN   = 2'd0,
    DIR_OUT  = 2'd1,
    DIR_BOTH = 2'd2
  } dir_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  // search beat moving down the row of cells
  typedef struct packed {
    logic               vld;
    logic               any;
    logic [1:0]         tbl;
    logic [15:0]        port;
    logic               hit;
    logic signed [7:0]  prio;
    logic               traf;
  } tok_t;

  // entry write broadcast to every cell
  typedef struct packed {
    logic [TableCount-1:0] we;
    logic [15:0]           port;
    logic signed [7:0]     prio;
    logic                  traf;
  } wr_t;

endpackage

[rtl/core/ppc_cell.sv]
// one cell of the search row: holds entry CELL_IDX of all four tables
// depends on ppc_pkg
module ppc_cell #(
  parameter int ENTRIES  = ppc_pkg::DefaultEntries,
  parameter int CELL_IDX = 0
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  ppc_pkg::tok_t                                  tok_i,
  input  logic [$clog2(ENTRIES+1)-1:0]                   left_i,
  input  ppc_pkg::wr_t                                   wr_i,
  input  logic [ppc_pkg::TableCount-1:0]
               [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] slot_i,
  output ppc_pkg::tok_t                                  tok_o,
  output logic [$clog2(ENTRIES+1)-1:0]                   left_o
);

  localparam int FW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [15:0]       port_q [ppc_pkg::TableCount];
  logic signed [7:0] prio_q [ppc_pkg::TableCount];
  logic              traf_q [ppc_pkg::TableCount];

  ppc_pkg::tok_t     tok_d, tok_q;
  logic [FW-1:0]     left_d, left_q;
  logic              match;

  // entry storage, written only by inserts
  always_ff @(posedge clk_i) begin
    for (int t = 0; t < ppc_pkg::TableCount; t++) begin
      if (wr_i.we[t] && (slot_i[t] == IW'(CELL_IDX))) begin
        port_q[t] <= wr_i.port;
        prio_q[t] <= wr_i.prio;
        traf_q[t] <= wr_i.traf;
      end
    end
  end

  // only entries below the fill count are compared
  assign match = tok_i.vld && !tok_i.hit && (left_i != '0) &&
                 (tok_i.any || (port_q[tok_i.tbl] == tok_i.port));

  always_comb begin
    tok_d = tok_i;
    if (match) begin
      tok_d.hit  = 1'b1;
      tok_d.prio = prio_q[tok_i.tbl];
      tok_d.traf = traf_q[tok_i.tbl];
    end
    left_d = (left_i != '0) ? (left_i - FW'(1)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      left_q <= '0;
    end else begin
      tok_q  <= tok_d;
      left_q <= left_d;
    end
  end

  assign tok_o  = tok_q;
  assign left_o = left_q;

endmodule

[rtl/core/port_priority_classifier.sv]
// top level of the port priority classifier: control, fill counts, icmp setting
// depends on ppc_pkg, ppc_cell and port_priority_classifier_defines.svh
//
// usage
//   input channel (in_valid_i / in_ready_o) carries one command beat: clear,
//   insert or lookup. output channel (out_valid_o / out_ready_i) returns
//   exactly one result beat per command, in order.
//   clear, insert, icmp lookup, lookup of a global table's wildcard excluded,
//   and unknown commands finish at once: the result beat is valid in the cycle
//   after the command beat is taken.
//   table lookups walk a row of ENTRIES cells, one cell per cycle; cell i holds
//   entry i of all four tables. the result beat is registered once the search
//   beat leaves the last cell, so a lookup finishes before the next command
//   is taken; other commands at one per cycle while the receiver is ready.
//   the length of the cell row alone sets the lookup latency.
//   a global table's lookup also walks the row and hits in cell 0.
//   in_ready_o is low while a lookup walks the row and while a result beat
//   waits on a stalled receiver; a result beat holds until out_ready_i.
//   reset empties all tables (fill counts and global flags cleared) and drops
//   the icmp setting; entry storage is not cleared and needs no sweep.
`include "port_priority_classifier_defines.svh"
module port_priority_classifier #(
  parameter int ENTRIES_PER_TABLE = ppc_pkg::DefaultEntries
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [1:0]        protocol_i,
  input  logic [1:0]        direction_i,
  input  logic [15:0]       port_number_i,
  input  logic signed [7:0] priority_in_i,
  input  logic              traffic_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              found_o,
  output logic signed [7:0] priority_out_o,
  output logic              traffic_out_o,
  output logic [1:0]        stored_mask_o
);

  localparam int N  = ENTRIES_PER_TABLE;
  localparam int TC = ppc_pkg::TableCount;
  localparam int FW = $clog2(N + 1);
  localparam int IW = (N > 1) ? $clog2(N) : 1;

  // control state
  ppc_pkg::state_e   state_q, state_d;
  logic [FW-1:0]     fill_q [TC];
  logic [FW-1:0]     fill_d [TC];
  logic [TC-1:0]     global_q, global_d;
  logic              icmp_vld_q, icmp_vld_d;
  logic signed [7:0] icmp_prio_q, icmp_prio_d;
  logic              icmp_traf_q, icmp_traf_d;

  // output register
  logic              out_vld_q, out_vld_d;
  logic              found_q, found_d;
  logic signed [7:0] prio_q, prio_d;
  logic              traf_q, traf_d;
  logic [1:0]        mask_q, mask_d;

  // decoded beat
  logic              in_acc;
  logic              is_clear, is_insert, is_lookup, is_tbl_proto, is_icmp;
  logic              port_zero, sel_in, sel_out, icmp_take;
  logic [1:0]        lk_tbl;
  logic [TC-1:0]     sel, take;

  // cell row
  ppc_pkg::tok_t     tok_w  [N+1];
  logic [FW-1:0]     left_w [N+1];
  ppc_pkg::wr_t      wr;
  logic [TC-1:0][IW-1:0] slot;

  assign in_ready_o = (state_q == ppc_pkg::ST_IDLE) && (!out_vld_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  assign is_clear     = in_acc && (command_i == ppc_pkg::CMD_CLEAR);
  assign is_insert    = in_acc && (command_i == ppc_pkg::CMD_INSERT);
  assign is_lookup    = in_acc && (command_i == ppc_pkg::CMD_LOOKUP);
  assign is_tbl_proto = (protocol_i == ppc_pkg::PROTO_UDP) ||
                        (protocol_i == ppc_pkg::PROTO_TCP);
  assign is_icmp      = (protocol_i == ppc_pkg::PROTO_ICMP);
  assign port_zero    = (port_number_i == 16'd0);

  // direction both writes the in table and the out table together
  assign sel_in  = is_insert && is_tbl_proto &&
                   ((direction_i == ppc_pkg::DIR_IN) || (direction_i == ppc_pkg::DIR_BOTH));
  assign sel_out = is_insert && is_tbl_proto &&
                   ((direction_i == ppc_pkg::DIR_OUT) || (direction_i == ppc_pkg::DIR_BOTH));
  assign icmp_take = is_insert && is_icmp && !icmp_vld_q;

  // table index: protocol picks the pair, direction the in or out half
  assign lk_tbl = {protocol_i[0], (direction_i != ppc_pkg::DIR_IN)};

  // per table insert decision, fill count and global flag
  always_comb begin
    for (int t = 0; t < TC; t++) begin
      sel[t]  = ((2'(t) == {protocol_i[0], 1'b0}) && sel_in) ||
                ((2'(t) == {protocol_i[0], 1'b1}) && sel_out);
      // wildcard always lands in slot 0; otherwise append unless global or full
      take[t] = sel[t] && (port_zero || (!global_q[t] && (fill_q[t] < FW'(N))));
      slot[t] = port_zero ? '0 : fill_q[t][IW-1:0];
      fill_d[t]   = fill_q[t];
      global_d[t] = global_q[t];
      if (is_clear) begin
        fill_d[t]   = '0;
        global_d[t] = 1'b0;
      end else if (take[t]) begin
        if (port_zero) begin
          fill_d[t]   = '0;
          global_d[t] = 1'b1;
        end else begin
          fill_d[t] = fill_q[t] + FW'(1);
        end
      end
    end
  end

  always_comb begin
    wr.we   = take;
    wr.port = port_number_i;
    wr.prio = priority_in_i;
    wr.traf = traffic_in_i;
  end

  // icmp setting is taken once until the next clear
  always_comb begin
    icmp_vld_d  = icmp_vld_q;
    icmp_prio_d = icmp_prio_q;
    icmp_traf_d = icmp_traf_q;
    if (is_clear) begin
      icmp_vld_d = 1'b0;
    end else if (icmp_take) begin
      icmp_vld_d  = 1'b1;
      icmp_prio_d = priority_in_i;
      icmp_traf_d = traffic_in_i;
    end
  end

  // search beat: a global table matches any port in cell 0 only
  always_comb begin
    tok_w[0].vld  = is_lookup && is_tbl_proto;
    tok_w[0].any  = global_q[lk_tbl];
    tok_w[0].tbl  = lk_tbl;
    tok_w[0].port = port_number_i;
    tok_w[0].hit  = 1'b0;
    tok_w[0].prio = '0;
    tok_w[0].traf = 1'b0;
    left_w[0]     = global_q[lk_tbl] ? FW'(1) : fill_q[lk_tbl];
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    ppc_cell #(
      .ENTRIES  (N),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok_w[i]),
      .left_i (left_w[i]),
      .wr_i   (wr),
      .slot_i (slot),
      .tok_o  (tok_w[i+1]),
      .left_o (left_w[i+1])
    );
  end

  // sequencer: idle takes beats, scan waits for the search beat to leave the row
  always_comb begin
    state_d = state_q;
    case (state_q)
      ppc_pkg::ST_IDLE: begin
        if (tok_w[0].vld) begin
          state_d = ppc_pkg::ST_SCAN;
        end
      end
      ppc_pkg::ST_SCAN: begin
        if (tok_w[N].vld) begin
          state_d = ppc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ppc_pkg::ST_IDLE;
      end
    endcase
  end

  // output register; a scan only starts with the register free, so the
  // search result never meets a pending beat
  always_comb begin
    out_vld_d = out_vld_q;
    found_d   = found_q;
    prio_d    = prio_q;
    traf_d    = traf_q;
    mask_d    = mask_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (tok_w[N].vld) begin
      out_vld_d = 1'b1;
      found_d   = tok_w[N].hit;
      prio_d    = tok_w[N].prio;
      traf_d    = tok_w[N].traf;
      mask_d    = 2'b00;
    end else if (in_acc && !tok_w[0].vld) begin
      out_vld_d = 1'b1;
      found_d   = is_lookup && is_icmp && icmp_vld_q;
      prio_d    = (is_lookup && is_icmp && icmp_vld_q) ? icmp_prio_q : 8'sd0;
      traf_d    = is_lookup && is_icmp && icmp_vld_q && icmp_traf_q;
      mask_d    = {take[1] | take[3], take[0] | take[2] | icmp_take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ppc_pkg::ST_IDLE;
      global_q   <= '0;
      icmp_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int t = 0; t < TC; t++) begin
        fill_q[t] <= '0;
      end
    end else begin
      state_q    <= state_d;
      global_q   <= global_d;
      icmp_vld_q <= icmp_vld_d;
      out_vld_q  <= out_vld_d;
      for (int t = 0; t < TC; t++) begin
        fill_q[t] <= fill_d[t];
      end
    end
  end

  // icmp setting reads zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icmp_prio_q <= '0;
      icmp_traf_q <= 1'b0;
    end else begin
      icmp_prio_q <= icmp_prio_d;
      icmp_traf_q <= icmp_traf_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    prio_q  <= prio_d;
    traf_q  <= traf_d;
    mask_q  <= mask_d;
  end

  assign out_valid_o    = out_vld_q;
  assign found_o        = found_q;
  assign priority_out_o = prio_q;
  assign traffic_out_o  = traf_q;
  assign stored_mask_o  = mask_q;

  // checks
  `PPC_ASSERT(a_exit_in_scan, tok_w[N].vld |-> (state_q == ppc_pkg::ST_SCAN), "search beat left the row outside a scan")
  `PPC_ASSERT(a_exit_count_done, tok_w[N].vld |-> (left_w[N] == '0), "search beat left the row with entries unvisited")
  `PPC_ASSERT(a_scan_out_free, tok_w[0].vld |=> !out_valid_o, "result beat present while a lookup walks the row")
  `PPC_ASSERT(a_fill_bounds, (fill_q[0] <= FW'(N)) && (fill_q[1] <= FW'(N)) && (fill_q[2] <= FW'(N)) && (fill_q[3] <= FW'(N)) && (!global_q[0] || (fill_q[0] == '0)) && (!global_q[1] || (fill_q[1] == '0)) && (!global_q[2] || (fill_q[2] == '0)) && (!global_q[3] || (fill_q[3] == '0)), "fill count out of range or global table not empty")

endmodule
